FILE: design/isodur_pkg.sv
// ============================================================================
// isodur_pkg
// Shared types, codes and character constants for the duration parser.
// ============================================================================
package isodur_pkg;

  // Component widths
  localparam int unsigned AMT_W  = 31;
  localparam int unsigned FRAC_W = 10;

  // Result status codes
  typedef enum logic [3:0] {
    STS_OK       = 4'd0,
    STS_EMPTY    = 4'd1,
    STS_NO_P     = 4'd2,
    STS_BAD_AMT  = 4'd3,
    STS_NO_TYPE  = 4'd4,
    STS_BAD_TYPE = 4'd5,
    STS_DECIMAL  = 4'd6,
    STS_ORDER    = 4'd7,
    STS_EXCESS   = 4'd8,
    STS_OVERFLOW = 4'd9
  } status_e;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_e;

  // Designator codes, in required order
  localparam logic [2:0] PART_NONE = 3'd0;
  localparam logic [2:0] PART_YEAR = 3'd1;
  localparam logic [2:0] PART_MON  = 3'd2;
  localparam logic [2:0] PART_DAY  = 3'd3;
  localparam logic [2:0] PART_HOUR = 3'd4;
  localparam logic [2:0] PART_MIN  = 3'd5;
  localparam logic [2:0] PART_SEC  = 3'd6;

  // Characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Finished-string word handed from front to back
  typedef struct packed {
    status_e             status;
    logic                neg;
    logic [AMT_W-1:0]    years;
    logic [AMT_W-1:0]    months;
    logic [AMT_W-1:0]    days;
    logic [AMT_W-1:0]    hours;
    logic [AMT_W-1:0]    minutes;
    logic [AMT_W-1:0]    seconds;
    logic [FRAC_W-1:0]   millis;
  } fin_t;

  // Parser state
  typedef struct packed {
    phase_e              phase;
    logic                neg;
    logic [AMT_W-1:0]    acc;
    logic                has_dig;
    logic                in_frac;
    logic [FRAC_W-1:0]   frac;
    logic [1:0]          fdig;
    logic [AMT_W-1:0]    yr;
    logic [AMT_W-1:0]    mo;
    logic [AMT_W-1:0]    dy;
    logic [AMT_W-1:0]    hr;
    logic [AMT_W-1:0]    mi;
    logic [AMT_W-1:0]    se;
    logic [FRAC_W-1:0]   ms;
    logic [2:0]          prev;
    logic                tseen;
    status_e             err;
  } pst_t;

  localparam pst_t PST_RESET = '{
    phase:   PH_LEAD,
    neg:     1'b0,
    acc:     '0,
    has_dig: 1'b0,
    in_frac: 1'b0,
    frac:    '0,
    fdig:    2'd0,
    yr:      '0,
    mo:      '0,
    dy:      '0,
    hr:      '0,
    mi:      '0,
    se:      '0,
    ms:      '0,
    prev:    PART_NONE,
    tseen:   1'b0,
    err:     STS_OK
  };

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

endpackage

FILE: design/isodur_if.sv
// ============================================================================
// isodur_if
// Valid/ready channels: character input and parse result output.
// ============================================================================
interface isodur_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface isodur_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic signed [31:0] months_total;
  logic signed [41:0] millis_total;

  modport source (output valid, output status, output months_total,
                  output millis_total, input ready);
  modport sink   (input valid, input status, input months_total,
                  input millis_total, output ready);
endinterface

FILE: design/isodur_front.sv
// ============================================================================
// isodur_front
// Character parser: one byte per cycle unless the queue is full, emits a finished word on the last byte.
// ============================================================================
module isodur_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  isodur_in_if.sink           in_i,
  input  logic                full_i,
  output logic                push_o,
  output isodur_pkg::fin_t    rec_o
);

  isodur_pkg::pst_t st_q, st_d;
  logic             fire;

  assign in_i.ready = !full_i;
  assign fire       = in_i.valid && in_i.ready;
  assign push_o     = fire && in_i.last_char;

  // Next parser state and finished word
  always_comb begin
    logic [7:0]                   c;
    logic [3:0]                   dig;
    logic [34:0]                  acc10;
    logic [2:0]                   part;
    logic [isodur_pkg::FRAC_W-1:0] mscaled;
    isodur_pkg::pst_t             nx;

    c     = in_i.char_code;
    dig   = c[3:0];
    acc10 = 35'(st_q.acc) * 35'd10 + 35'(dig);
    nx    = st_q;

    // Designator decode
    part = isodur_pkg::PART_NONE;
    if (c == isodur_pkg::CH_Y)      part = isodur_pkg::PART_YEAR;
    else if (c == isodur_pkg::CH_M) part = st_q.tseen ? isodur_pkg::PART_MIN
                                                      : isodur_pkg::PART_MON;
    else if (c == isodur_pkg::CH_D) part = isodur_pkg::PART_DAY;
    else if (c == isodur_pkg::CH_H) part = isodur_pkg::PART_HOUR;
    else if (c == isodur_pkg::CH_S) part = isodur_pkg::PART_SEC;

    // Scale the kept fraction to milliseconds
    case (st_q.fdig)
      2'd1:    mscaled = 10'(17'(st_q.frac) * 17'd100);
      2'd2:    mscaled = 10'(17'(st_q.frac) * 17'd10);
      2'd3:    mscaled = st_q.frac;
      default: mscaled = '0;
    endcase

    if (fire && st_q.err == isodur_pkg::STS_OK) begin
      unique case (st_q.phase)
        isodur_pkg::PH_LEAD: begin
          if (isodur_pkg::is_ws(c)) begin
            nx.phase = isodur_pkg::PH_LEAD;
          end else if (c == isodur_pkg::CH_MINUS) begin
            nx.neg   = 1'b1;
            nx.phase = isodur_pkg::PH_SIGN;
          end else if (c == isodur_pkg::CH_P) begin
            nx.phase = isodur_pkg::PH_BODY;
          end else begin
            nx.err = isodur_pkg::STS_NO_P;
          end
        end
        isodur_pkg::PH_SIGN: begin
          if (c == isodur_pkg::CH_P) nx.phase = isodur_pkg::PH_BODY;
          else                       nx.err   = isodur_pkg::STS_NO_P;
        end
        isodur_pkg::PH_BODY: begin
          logic do_des;
          do_des = 1'b0;
          if (st_q.in_frac) begin
            if (isodur_pkg::is_digit(c)) begin
              if (st_q.fdig != 2'd3) begin
                nx.frac = 10'(14'(st_q.frac) * 14'd10 + 14'(dig));
                nx.fdig = st_q.fdig + 2'd1;
              end
            end else if (st_q.fdig == 2'd0) begin
              nx.err = isodur_pkg::STS_BAD_AMT;
            end else begin
              do_des = 1'b1;
            end
          end else if (st_q.has_dig) begin
            if (isodur_pkg::is_digit(c)) begin
              if (|acc10[34:31]) nx.err = isodur_pkg::STS_OVERFLOW;
              else               nx.acc = acc10[30:0];
            end else if (c == isodur_pkg::CH_DOT) begin
              nx.in_frac = 1'b1;
            end else begin
              do_des = 1'b1;
            end
          end else begin
            if (c == isodur_pkg::CH_T) begin
              nx.tseen = 1'b1;
            end else if (isodur_pkg::is_ws(c)) begin
              nx.phase = isodur_pkg::PH_TRAIL;
            end else if (isodur_pkg::is_digit(c)) begin
              if (|acc10[34:31]) begin
                nx.err = isodur_pkg::STS_OVERFLOW;
              end else begin
                nx.acc     = acc10[30:0];
                nx.has_dig = 1'b1;
              end
            end else begin
              nx.err = isodur_pkg::STS_BAD_AMT;
            end
          end

          // Designator closes an amount
          if (do_des) begin
            if (part == isodur_pkg::PART_NONE) begin
              nx.err = isodur_pkg::STS_BAD_TYPE;
            end else if (st_q.in_frac && part != isodur_pkg::PART_SEC) begin
              nx.err = isodur_pkg::STS_DECIMAL;
            end else if (part <= st_q.prev ||
                         (part > isodur_pkg::PART_DAY && !st_q.tseen)) begin
              nx.err = isodur_pkg::STS_ORDER;
            end else begin
              case (part)
                isodur_pkg::PART_YEAR: nx.yr = st_q.acc;
                isodur_pkg::PART_MON:  nx.mo = st_q.acc;
                isodur_pkg::PART_DAY:  nx.dy = st_q.acc;
                isodur_pkg::PART_HOUR: nx.hr = st_q.acc;
                isodur_pkg::PART_MIN:  nx.mi = st_q.acc;
                default: begin
                  nx.se = st_q.acc;
                  nx.ms = st_q.in_frac ? mscaled : '0;
                end
              endcase
              nx.prev    = part;
              nx.acc     = '0;
              nx.has_dig = 1'b0;
              nx.in_frac = 1'b0;
              nx.frac    = '0;
              nx.fdig    = 2'd0;
            end
          end
        end
        isodur_pkg::PH_TRAIL: begin
          if (!isodur_pkg::is_ws(c)) nx.err = isodur_pkg::STS_EXCESS;
        end
        default: nx.phase = isodur_pkg::PH_LEAD;
      endcase
    end

    // End-of-string status
    rec_o.status = nx.err;
    if (nx.err == isodur_pkg::STS_OK) begin
      unique case (nx.phase)
        isodur_pkg::PH_LEAD: rec_o.status = isodur_pkg::STS_EMPTY;
        isodur_pkg::PH_SIGN: rec_o.status = isodur_pkg::STS_NO_P;
        isodur_pkg::PH_BODY: begin
          if (nx.in_frac)
            rec_o.status = (nx.fdig == 2'd0) ? isodur_pkg::STS_BAD_AMT
                                             : isodur_pkg::STS_NO_TYPE;
          else if (nx.has_dig)
            rec_o.status = isodur_pkg::STS_NO_TYPE;
        end
        default: rec_o.status = isodur_pkg::STS_OK;
      endcase
    end
    rec_o.neg     = nx.neg;
    rec_o.years   = nx.yr;
    rec_o.months  = nx.mo;
    rec_o.days    = nx.dy;
    rec_o.hours   = nx.hr;
    rec_o.minutes = nx.mi;
    rec_o.seconds = nx.se;
    rec_o.millis  = nx.ms;

    // Start over after the last byte
    st_d = push_o ? isodur_pkg::PST_RESET : nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= isodur_pkg::PST_RESET;
    end else begin
      st_q <= st_d;
    end
  end

  // A finished string leaves the parser clean
  ap_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (st_q.phase == isodur_pkg::PH_LEAD && st_q.err == isodur_pkg::STS_OK))
    else $error("parser not reset after last byte");

endmodule

FILE: design/isodur_fifo.sv
// ============================================================================
// isodur_fifo
// Two-entry queue of finished words between parser and arithmetic back end.
// ============================================================================
module isodur_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  isodur_pkg::fin_t    rec_i,
  output logic                full_o,
  output logic                valid_o,
  output isodur_pkg::fin_t    rec_o,
  input  logic                pop_i
);

  isodur_pkg::fin_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rec_o   = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rec_i;
  end

  ap_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  ap_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  ap_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

endmodule

FILE: design/isodur_back.sv
// ============================================================================
// isodur_back
// Totals pipeline: products, sums with overflow check, millis, sign and output.
// ============================================================================
module isodur_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  isodur_pkg::fin_t    rec_i,
  output logic                ready_o,
  isodur_out_if.source        out_o
);

  logic en;

  // Stage 1: constant products
  logic               v1_q;
  isodur_pkg::status_e st1_q;
  logic               neg1_q;
  logic [34:0]        ym1_q;
  logic [30:0]        mo1_q;
  logic [47:0]        d1_q;
  logic [42:0]        h1_q;
  logic [36:0]        mi1_q;
  logic [30:0]        s1_q;
  logic [9:0]         ms1_q;

  // Stage 2: totals and overflow
  logic               v2_q;
  isodur_pkg::status_e st2_q;
  logic               neg2_q;
  logic [30:0]        mo2_q;
  logic [30:0]        sec2_q;
  logic [9:0]         ms2_q;

  // Stage 3: milliseconds
  logic               v3_q;
  isodur_pkg::status_e st3_q;
  logic               neg3_q;
  logic [30:0]        mo3_q;
  logic [40:0]        mil3_q;

  // Output register
  logic               vo_q;
  isodur_pkg::status_e sto_q;
  logic [31:0]        moo_q;
  logic [41:0]        milo_q;

  logic [35:0]        months_sum;
  logic [48:0]        secs_sum;
  logic               ovf;
  logic [40:0]        mil_prod;
  logic [31:0]        mo_ext;
  logic [41:0]        mil_ext;

  assign en      = !vo_q || out_o.ready;
  assign ready_o = en;

  assign months_sum = 36'(ym1_q) + 36'(mo1_q);
  assign secs_sum   = 49'(d1_q) + 49'(h1_q) + 49'(mi1_q) + 49'(s1_q);
  assign ovf        = (|months_sum[35:31]) || (|secs_sum[48:31]);
  assign mil_prod   = 41'(sec2_q) * 41'd1000 + 41'(ms2_q);
  assign mo_ext     = {1'b0, mo3_q};
  assign mil_ext    = {1'b0, mil3_q};

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q  <= rec_i.status;
      neg1_q <= rec_i.neg;
      ym1_q  <= 35'(rec_i.years) * 35'd12;
      mo1_q  <= rec_i.months;
      d1_q   <= 48'(rec_i.days) * 48'd86400;
      h1_q   <= 43'(rec_i.hours) * 43'd3600;
      mi1_q  <= 37'(rec_i.minutes) * 37'd60;
      s1_q   <= rec_i.seconds;
      ms1_q  <= rec_i.millis;

      st2_q  <= (st1_q == isodur_pkg::STS_OK && ovf) ? isodur_pkg::STS_OVERFLOW : st1_q;
      neg2_q <= neg1_q;
      mo2_q  <= months_sum[30:0];
      sec2_q <= secs_sum[30:0];
      ms2_q  <= ms1_q;

      st3_q  <= st2_q;
      neg3_q <= neg2_q;
      mo3_q  <= mo2_q;
      mil3_q <= mil_prod;

      sto_q  <= st3_q;
      if (st3_q != isodur_pkg::STS_OK) begin
        moo_q  <= '0;
        milo_q <= '0;
      end else if (neg3_q) begin
        moo_q  <= 32'd0 - mo_ext;
        milo_q <= 42'd0 - mil_ext;
      end else begin
        moo_q  <= mo_ext;
        milo_q <= mil_ext;
      end
    end
  end

  assign out_o.valid        = vo_q;
  assign out_o.status       = sto_q;
  assign out_o.months_total = $signed(moo_q);
  assign out_o.millis_total = $signed(milo_q);

  ap_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != isodur_pkg::STS_OK) |->
      (out_o.months_total == 32'sd0 && out_o.millis_total == 42'sd0))
    else $error("nonzero totals on error status");

endmodule

FILE: design/iso8601_duration_parser_top.sv
// ============================================================================
// iso8601_duration_parser_top
// Streaming duration text parser with months and milliseconds totals.
// ============================================================================
// Throughput: one character per cycle unless the queue is full, strings of any length back to back.
// Path: after its last character is accepted, a result passes through the
//   queue, product stage, sum/overflow stage, millis stage and output register.
// The two-entry queue lets the parser run on while the output is stalled, until the queue is full.
// Reset: asynchronous, active low; parser back to leading whitespace, queue
//   and pipeline emptied.
module iso8601_duration_parser_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  isodur_in_if.sink     in_i,
  isodur_out_if.source  out_o
);

  logic             push;
  logic             full;
  logic             q_valid;
  logic             q_pop;
  logic             back_ready;
  isodur_pkg::fin_t rec_in;
  isodur_pkg::fin_t rec_out;

  assign q_pop = q_valid && back_ready;

  isodur_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .rec_o  (rec_in)
  );

  isodur_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .valid_o (q_valid),
    .rec_o   (rec_out),
    .pop_i   (q_pop)
  );

  isodur_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .rec_i   (rec_out),
    .ready_o (back_ready),
    .out_o   (out_o)
  );

endmodule
